/* hdl/assert_macros.svh */
// Assertion macros included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge outside reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check prop at every rising clk edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* hdl/i2cbe_pkg.sv */
// Package: command codes, sequencer states and inter-module structs
package i2cbe_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int CNT_W         = $clog2(BITS_PER_BYTE);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_BYTE - 1);

  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_STOP   = 3'd1;
  localparam logic [2:0] KIND_WRITE  = 3'd2;
  localparam logic [2:0] KIND_READ   = 3'd3;
  localparam logic [2:0] KIND_ACK_TX = 3'd4;
  localparam logic [2:0] KIND_ACK_RX = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START_SDA1, ST_START_SCL1, ST_START_SDA0, ST_START_SCL0,
    ST_STOP_SDA0, ST_STOP_SCL1, ST_STOP_SDA1,
    ST_WR_SDA, ST_WR_SCL1, ST_WR_SCL0,
    ST_RD_SDA1, ST_RD_SCL1, ST_RD_SCL0,
    ST_ACK_SDA, ST_ACK_SCL1, ST_ACK_SCL0,
    ST_RA_SDA1, ST_RA_SCL1, ST_RA_SCL0
  } seq_state_t;

  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_BYTE,
    VAL_ACK
  } val_sel_t;

  typedef struct packed {
    logic     act;
    logic     set_scl;
    logic     level;
    logic     last;
    val_sel_t val_sel;
  } phase_t;

  typedef struct packed {
    logic load;
    logic tx_shift;
    logic rx_sample;
  } shift_ctl_t;

endpackage

/* hdl/i2cbe_shift.sv */
// Bit-serial transmit and receive shift registers
module i2cbe_shift (
  input  logic                   clk,
  input  i2cbe_pkg::shift_ctl_t  ctl,
  input  logic [7:0]             tx_byte,
  input  logic [7:0]             bus_bits,
  output logic                   tx_bit,
  output logic                   ack_bit,
  output logic [7:0]             rx_byte
);
  import i2cbe_pkg::*;

  logic [7:0] tx_sr;
  logic [7:0] bus_sr;
  logic [7:0] rx_sr;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tx_sr  <= tx_byte;
      bus_sr <= bus_bits;
    end else begin
      if (ctl.tx_shift) begin
        tx_sr <= {tx_sr[6:0], 1'b0};
      end
      if (ctl.rx_sample) begin
        bus_sr <= {bus_sr[6:0], 1'b0};
        rx_sr  <= {rx_sr[6:0], bus_sr[7]};
      end
    end
  end

  assign tx_bit  = tx_sr[7];
  assign ack_bit = bus_sr[7];
  assign rx_byte = rx_sr;

endmodule

/* hdl/i2cbe_seq.sv */
// Phase sequencer: one SCL or SDA assignment per cycle while go is high
module i2cbe_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [2:0]             kind,
  input  logic                   ack_out,
  input  logic                   go,
  input  logic                   tx_bit,
  output logic                   busy,
  output i2cbe_pkg::phase_t      phase,
  output i2cbe_pkg::shift_ctl_t  ctl
);
  import i2cbe_pkg::*;

  seq_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             ack_level, ack_level_next;
  logic             bit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    ack_level <= ack_level_next;
  end

  assign busy     = (state != ST_IDLE);
  assign bit_last = (cnt == LAST_BIT);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    ack_level_next = ack_level;
    phase          = '{act: 1'b0, set_scl: 1'b0, level: 1'b1, last: 1'b0,
                       val_sel: VAL_ZERO};
    ctl            = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load       = 1'b1;
          cnt_next       = '0;
          ack_level_next = ack_out;
          unique case (kind)
            KIND_START:  state_next = ST_START_SDA1;
            KIND_STOP:   state_next = ST_STOP_SDA0;
            KIND_WRITE:  state_next = ST_WR_SDA;
            KIND_READ:   state_next = ST_RD_SDA1;
            KIND_ACK_TX: state_next = ST_ACK_SDA;
            KIND_ACK_RX: state_next = ST_RA_SDA1;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_START_SDA1: begin
        phase.act = 1'b1; phase.level = 1'b1;
        if (go) state_next = ST_START_SCL1;
      end
      ST_START_SCL1: begin
        phase.act = 1'b1; phase.set_scl = 1'b1; phase.level = 1'b1;
        if (go) state_next = ST_START_SDA0;
      end
      ST_START_SDA0: begin
        phase.act = 1'b1; phase.level = 1'b0;
        if (go) state_next = ST_START_SCL0;
      end
      ST_START_SCL0: begin
        phase.act = 1'b1; phase.set_scl = 1'b1; phase.level = 1'b0;
        phase.last = 1'b1;
        if (go) state_next = ST_IDLE;
      end
      ST_STOP_SDA0: begin
        phase.act = 1'b1; phase.level = 1'b0;
        if (go) state_next = ST_STOP_SCL1;
      end
      ST_STOP_SCL1: begin
        phase.act = 1'b1; phase.set_scl = 1'b1; phase.level = 1'b1;
        if (go) state_next = ST_STOP_SDA1;
      end
      ST_STOP_SDA1: begin
        phase.act = 1'b1; phase.level = 1'b1; phase.last = 1'b1;
        if (go) state_next = ST_IDLE;
      end
      ST_WR_SDA: begin
        phase.act = 1'b1; phase.level = tx_bit;
        if (go) state_next = ST_WR_SCL1;
      end
      ST_WR_SCL1: begin
        phase.act = 1'b1; phase.set_scl = 1'b1; phase.level = 1'b1;
        if (go) state_next = ST_WR_SCL0;
      end
      ST_WR_SCL0: begin
        phase.act = 1'b1; phase.set_scl = 1'b1; phase.level = 1'b0;
        phase.last = bit_last;
        if (go) begin
          ctl.tx_shift = 1'b1;
          cnt_next     = cnt + 1'b1;
          state_next   = bit_last ? ST_IDLE : ST_WR_SDA;
        end
      end
      ST_RD_SDA1: begin
        phase.act = 1'b1; phase.level = 1'b1;
        if (go) state_next = ST_RD_SCL1;
      end
      ST_RD_SCL1: begin
        phase.act = 1'b1; phase.set_scl = 1'b1; phase.level = 1'b1;
        if (go) begin
          ctl.rx_sample = 1'b1;
          state_next    = ST_RD_SCL0;
        end
      end
      ST_RD_SCL0: begin
        phase.act = 1'b1; phase.set_scl = 1'b1; phase.level = 1'b0;
        phase.last    = bit_last;
        phase.val_sel = bit_last ? VAL_BYTE : VAL_ZERO;
        if (go) begin
          cnt_next   = cnt + 1'b1;
          state_next = bit_last ? ST_IDLE : ST_RD_SCL1;
        end
      end
      ST_ACK_SDA: begin
        phase.act = 1'b1; phase.level = ack_level;
        if (go) state_next = ST_ACK_SCL1;
      end
      ST_ACK_SCL1: begin
        phase.act = 1'b1; phase.set_scl = 1'b1; phase.level = 1'b1;
        if (go) state_next = ST_ACK_SCL0;
      end
      ST_ACK_SCL0: begin
        phase.act = 1'b1; phase.set_scl = 1'b1; phase.level = 1'b0;
        phase.last = 1'b1;
        if (go) state_next = ST_IDLE;
      end
      ST_RA_SDA1: begin
        phase.act = 1'b1; phase.level = 1'b1;
        if (go) state_next = ST_RA_SCL1;
      end
      ST_RA_SCL1: begin
        phase.act = 1'b1; phase.set_scl = 1'b1; phase.level = 1'b1;
        if (go) state_next = ST_RA_SCL0;
      end
      ST_RA_SCL0: begin
        phase.act = 1'b1; phase.set_scl = 1'b1; phase.level = 1'b0;
        phase.last = 1'b1; phase.val_sel = VAL_ACK;
        if (go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* hdl/i2c_master_bit_engine_unit.sv */
// Top level: I2C master pin-phase engine with registered result output
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall  kind, tx_byte, ack_out, bus_bits
//   out      out  out_valid / out_stall scl_level, sda_level, read_value, last
//
// One pin phase leaves per cycle unless out_stall holds the output; a command is
// accepted while the sequencer is idle and then issues its pin phases.
// Kinds 6 and 7 are accepted and give no transaction.
// The phase sequencer sets the rate; the bit shift registers move one bit per SCL pulse.
// Reset releases both pins and idles the sequencer.
// out_stall holds the sequencer on the current phase; in_stall is high while
// a command's phases are still being generated.
module i2c_master_bit_engine_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [7:0] tx_byte,
  input  logic       ack_out,
  input  logic [7:0] bus_bits,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_level,
  output logic       sda_level,
  output logic [7:0] read_value,
  output logic       last
);
  import i2cbe_pkg::*;
  `include "assert_macros.svh"

  phase_t     phase;
  shift_ctl_t ctl;
  logic       go;
  logic       busy;
  logic       tx_bit;
  logic       ack_bit;
  logic [7:0] rx_byte;
  logic       scl_pin, scl_pin_next;
  logic       sda_pin, sda_pin_next;
  logic [7:0] value_next;

  assign go       = !out_valid || !out_stall;
  assign in_stall = busy;

  i2cbe_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .ack_out  (ack_out),
    .go       (go),
    .tx_bit   (tx_bit),
    .busy     (busy),
    .phase    (phase),
    .ctl      (ctl)
  );

  i2cbe_shift u_shift (
    .clk      (clk),
    .ctl      (ctl),
    .tx_byte  (tx_byte),
    .bus_bits (bus_bits),
    .tx_bit   (tx_bit),
    .ack_bit  (ack_bit),
    .rx_byte  (rx_byte)
  );

  always_comb begin
    scl_pin_next = phase.set_scl ? phase.level : scl_pin;
    sda_pin_next = phase.set_scl ? sda_pin : phase.level;
    unique case (phase.val_sel)
      VAL_BYTE: value_next = rx_byte;
      VAL_ACK:  value_next = {7'b0, ack_bit};
      default:  value_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_pin   <= 1'b1;
      sda_pin   <= 1'b1;
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= phase.act;
      if (phase.act) begin
        scl_pin <= scl_pin_next;
        sda_pin <= sda_pin_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && phase.act) begin
      scl_level  <= scl_pin_next;
      sda_level  <= sda_pin_next;
      read_value <= value_next;
      last       <= phase.last;
    end
  end

  `ASSERT_CLK(a_cmd_goes_busy, (in_valid && !in_stall && (kind <= KIND_ACK_RX)) |=> in_stall)
  `ASSERT_CLK(a_last_frees_seq, $rose(out_valid && last) |-> !in_stall)
  `ASSERT_CLK(a_out_matches_pins, out_valid |-> (scl_level == scl_pin && sda_level == sda_pin))
  `ASSERT_CLK(a_last_pin_pair, (out_valid && last) |-> (!scl_level || sda_level))

endmodule

/* sim/i2c_master_bit_engine_unit_tb.sv */
// Testbench for the I2C master pin-phase engine: directed and random command streams
module i2c_master_bit_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cbe_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] KIND_UNDEF_LO = 3'd6;
  localparam logic [2:0] KIND_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] value;
    logic       fin;
  } pin_phase_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] kind = '0;
  logic [7:0] tx_byte = '0;
  logic       ack_out = 1'b0;
  logic [7:0] bus_bits = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_level;
  logic       sda_level;
  logic [7:0] read_value;
  logic       last;

  pin_phase_t phase_q[$];
  logic       line_scl = 1'b1;
  logic       line_sda = 1'b1;
  int         src_gap_max = 6;
  int         sink_hold_max = 6;
  int         cmd_count[8];
  int         phases_checked = 0;
  int         mismatches = 0;
  int         cycles = 0;

  i2c_master_bit_engine_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d pin phases outstanding", $realtime, phase_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void log_phase(logic [7:0] value, logic fin);
    phase_q.push_back('{scl: line_scl, sda: line_sda, value: value, fin: fin});
  endfunction

  function automatic void set_sda_line(logic level, logic [7:0] value, logic fin);
    line_sda = level;
    log_phase(value, fin);
  endfunction

  function automatic void set_scl_line(logic level, logic [7:0] value, logic fin);
    line_scl = level;
    log_phase(value, fin);
  endfunction

  function automatic void predict_pin_phases(logic [2:0] k, logic [7:0] tx, logic ack,
                                             logic [7:0] bus);
    logic [7:0] rx;
    rx = '0;
    case (k)
      KIND_START: begin
        set_sda_line(1'b1, '0, 1'b0);
        set_scl_line(1'b1, '0, 1'b0);
        set_sda_line(1'b0, '0, 1'b0);
        set_scl_line(1'b0, '0, 1'b1);
      end
      KIND_STOP: begin
        set_sda_line(1'b0, '0, 1'b0);
        set_scl_line(1'b1, '0, 1'b0);
        set_sda_line(1'b1, '0, 1'b1);
      end
      KIND_WRITE: begin
        for (int b = BITS_PER_BYTE - 1; b >= 0; b--) begin
          set_sda_line(tx[b], '0, 1'b0);
          set_scl_line(1'b1, '0, 1'b0);
          set_scl_line(1'b0, '0, b == 0);
        end
      end
      KIND_READ: begin
        set_sda_line(1'b1, '0, 1'b0);
        for (int b = BITS_PER_BYTE - 1; b >= 0; b--) begin
          set_scl_line(1'b1, '0, 1'b0);
          rx[b] = bus[b];
          set_scl_line(1'b0, (b == 0) ? rx : 8'h00, b == 0);
        end
      end
      KIND_ACK_TX: begin
        set_sda_line(ack, '0, 1'b0);
        set_scl_line(1'b1, '0, 1'b0);
        set_scl_line(1'b0, '0, 1'b1);
      end
      KIND_ACK_RX: begin
        set_sda_line(1'b1, '0, 1'b0);
        set_scl_line(1'b1, '0, 1'b0);
        set_scl_line(1'b0, {7'b0, bus[7]}, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_command(logic [2:0] k, logic [7:0] tx, logic ack, logic [7:0] bus);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    tx_byte  <= tx;
    ack_out  <= ack;
    bus_bits <= bus;
    do @(posedge clk); while (in_stall);
    predict_pin_phases(k, tx, ack, bus);
    cmd_count[k]++;
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold off the result channel for a random count before each transaction
  initial begin
    int hold;
    forever begin
      hold = $urandom_range(0, sink_hold_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic void report_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $realtime, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    pin_phase_t want;
    if (!rst && out_valid && !out_stall) begin
      if (phase_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual scl=%0b sda=%0b %02h last=%0b",
                 $realtime, scl_level, sda_level, read_value, last);
        mismatches++;
      end else begin
        want = phase_q.pop_front();
        report_field("scl_level", 8'(want.scl), 8'(scl_level));
        report_field("sda_level", 8'(want.sda), 8'(sda_level));
        report_field("read_value", want.value, read_value);
        report_field("last", 8'(want.fin), 8'(last));
        phases_checked++;
      end
    end
  end

  task automatic test_directed();
    src_gap_max   = 3;
    sink_hold_max = 3;
    send_command(KIND_START, 8'hFF, 1'b1, 8'hFF);
    send_command(KIND_WRITE, 8'h00, 1'b1, 8'hFF);
    send_command(KIND_WRITE, 8'hFF, 1'b0, 8'h00);
    send_command(KIND_WRITE, 8'hA5, 1'b1, 8'h5A);
    send_command(KIND_ACK_RX, 8'h00, 1'b0, 8'h80);
    send_command(KIND_ACK_RX, 8'hFF, 1'b1, 8'h7F);
    send_command(KIND_ACK_TX, 8'hFF, 1'b0, 8'hFF);
    send_command(KIND_ACK_TX, 8'h00, 1'b1, 8'h00);
    send_command(KIND_READ, 8'hFF, 1'b0, 8'h00);
    send_command(KIND_READ, 8'h00, 1'b1, 8'hFF);
    send_command(KIND_READ, 8'hA5, 1'b0, 8'h5A);
    send_command(KIND_READ, 8'h5A, 1'b1, 8'hA5);
    send_command(KIND_STOP, 8'hFF, 1'b0, 8'hFF);
    send_command(KIND_UNDEF_LO, 8'hFF, 1'b1, 8'hFF);
    send_command(KIND_UNDEF_HI, 8'h00, 1'b0, 8'h00);
    send_command(KIND_STOP, 8'h00, 1'b1, 8'h00);
    send_command(KIND_START, 8'h00, 1'b0, 8'h00);
    send_command(KIND_START, 8'h55, 1'b1, 8'hAA);
    send_command(KIND_READ, 8'h00, 1'b0, 8'h81);
    send_command(KIND_UNDEF_HI, 8'hFF, 1'b1, 8'h00);
    send_command(KIND_ACK_TX, 8'h00, 1'b1, 8'h00);
    send_command(KIND_STOP, 8'h00, 1'b0, 8'h00);
  endtask

  task automatic send_address(logic rd);
    send_command(KIND_WRITE, {7'($urandom), rd}, rand_bit(), rand_byte());
    send_command(KIND_ACK_RX, rand_byte(), rand_bit(), rand_byte());
  endtask

  task automatic test_transfers(int frames);
    int   nbytes;
    logic rd;
    logic quiet;
    for (int f = 0; f < frames; f++) begin
      quiet         = ($urandom_range(0, 3) == 0);
      src_gap_max   = quiet ? 0 : 6;
      sink_hold_max = quiet ? 0 : 6;
      rd            = rand_bit();
      send_command(KIND_START, rand_byte(), rand_bit(), rand_byte());
      send_address(rd);
      nbytes = $urandom_range(1, 4);
      for (int b = 0; b < nbytes; b++) begin
        if (rd) begin
          send_command(KIND_READ, rand_byte(), rand_bit(), rand_byte());
          send_command(KIND_ACK_TX, rand_byte(), b == nbytes - 1, rand_byte());
        end else begin
          send_command(KIND_WRITE, rand_byte(), rand_bit(), rand_byte());
          send_command(KIND_ACK_RX, rand_byte(), rand_bit(), rand_byte());
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        send_command(KIND_START, rand_byte(), rand_bit(), rand_byte());
        send_address(1'b1);
        send_command(KIND_READ, rand_byte(), rand_bit(), rand_byte());
        send_command(KIND_ACK_TX, rand_byte(), 1'b1, rand_byte());
      end
      send_command(KIND_STOP, rand_byte(), rand_bit(), rand_byte());
    end
  endtask

  task automatic test_noise(int count);
    src_gap_max   = 6;
    sink_hold_max = 6;
    repeat (count) begin
      send_command(3'($urandom_range(0, 7)), rand_byte(), rand_bit(), rand_byte());
    end
  endtask

  task automatic test_back_to_back(int count);
    src_gap_max   = 0;
    sink_hold_max = 0;
    repeat (count) begin
      send_command(3'($urandom_range(0, 5)), rand_byte(), rand_bit(), rand_byte());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_transfers(9);
    test_noise(40);
    test_back_to_back(24);
    release_input();
    while (phase_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Commands: start %0d, stop %0d, write %0d, read %0d, send ack %0d, read ack %0d",
             cmd_count[KIND_START], cmd_count[KIND_STOP], cmd_count[KIND_WRITE],
             cmd_count[KIND_READ], cmd_count[KIND_ACK_TX], cmd_count[KIND_ACK_RX]);
    $display("Undefined kinds %0d; pin phases checked %0d; mismatches %0d",
             cmd_count[KIND_UNDEF_LO] + cmd_count[KIND_UNDEF_HI], phases_checked, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/i2cbe_pkg.sv
hdl/i2cbe_shift.sv
hdl/i2cbe_seq.sv
hdl/i2c_master_bit_engine_unit.sv
sim/i2c_master_bit_engine_unit_tb.sv
